// ----- src/assert_macros.svh -----
// Assertion macros shared by the matcher RTL.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge, off while reset is held.
`define SDM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define SDM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/sdm_pkg.sv -----
// Shared types and constants of the template digit matcher.
// No dependencies; imported by the template RAM and the top level.
`timescale 1ns / 1ps
`default_nettype none

package sdm_pkg;

  localparam int NUM_TEMPLATES_DEF       = 33;
  localparam int TEMPLATES_PER_CLASS_DEF = 8;
  localparam int IMAGE_SIDE_DEF          = 100;

  localparam int PIX_W   = 8;
  localparam int SUM_W   = 22;
  localparam int CLASS_W = 4;

  localparam logic [SUM_W-1:0]   THRESHOLD_RESET   = SUM_W'(320000);
  localparam logic [CLASS_W-1:0] EXTRA_CLASS_RESET = CLASS_W'(4);

  // Configuration register indexes
  localparam logic CFG_SAD_THRESHOLD = 1'b0;
  localparam logic CFG_EXTRA_CLASS   = 1'b1;

  typedef logic [PIX_W-1:0] pixel_t;
  typedef logic [SUM_W-1:0] sum_t;

endpackage

`default_nettype wire

// ----- src/sdm_tmpl_ram.sv -----
// Template pixel store: one write port, one read port, registered read data.
// Depends on sdm_pkg for the pixel type.
`timescale 1ns / 1ps
`default_nettype none

module sdm_tmpl_ram
  import sdm_pkg::*;
#(
  parameter int DEPTH  = NUM_TEMPLATES_DEF * IMAGE_SIDE_DEF * IMAGE_SIDE_DEF,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire pixel_t            wr_data,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output pixel_t                 rd_data
);

  pixel_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ----- src/sad_template_digit_matcher_unit.sv -----
// Top level of the SAD template digit matcher: sum memory, scan sequencer, result register.
// Depends on sdm_pkg, sdm_tmpl_ram and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// Usage:
//   Input words are taken when start is high and busy is low. A word with
//   in_req_type = 0 writes one template pixel in the accept cycle; busy stays
//   low, so loads run at one word per cycle.
//   A word with in_req_type = 1 is a candidate pixel. The sequencer walks all
//   NUM_TEMPLATES templates, one per cycle: it reads the template pixel and the
//   running sum, adds the absolute difference with saturation and writes the
//   sum back. busy stays high while the sequencer is in its scan and drain
//   states. On a candidate word with in_last_pixel set, the same pass
//   compares every updated sum against the threshold, keeps the first hit,
//   clears the sums, and raises out_strobe for one cycle right after busy
//   falls. The receiver cannot stall.
//   The cfg channel is always ready; write it only while the block is idle.
//   Reset (rst_n low, synchronous) returns the sequencer to idle, restores the
//   threshold and extra class and marks all sums as zero. Template pixels are
//   undefined until loaded.
module sad_template_digit_matcher_unit
  import sdm_pkg::*;
#(
  parameter int NUM_TEMPLATES       = NUM_TEMPLATES_DEF,
  parameter int TEMPLATES_PER_CLASS = TEMPLATES_PER_CLASS_DEF,
  parameter int IMAGE_SIDE          = IMAGE_SIDE_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               in_req_type,
  input  wire logic [5:0]         in_template_index,
  input  wire logic [13:0]        in_pixel_index,
  input  wire logic [7:0]         in_pixel_value,
  input  wire logic               in_last_pixel,
  output logic                    out_strobe,
  output logic                    out_match_found,
  output logic [CLASS_W-1:0]      out_digit_class,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic               cfg_index,
  input  wire logic [SUM_W-1:0]   cfg_data
);

  localparam int PIX     = IMAGE_SIDE * IMAGE_SIDE;
  localparam int DEPTH   = NUM_TEMPLATES * PIX;
  localparam int TMPL_AW = $clog2(DEPTH);
  localparam int TW      = $clog2(NUM_TEMPLATES);
  localparam logic [TW-1:0] LAST_T = TW'(NUM_TEMPLATES - 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  logic [1:0]         state_r;
  logic [TW-1:0]      step_r;
  logic [TMPL_AW-1:0] addr_r;
  pixel_t             px_r;
  logic               in_range_r;
  logic               last_r;

  logic               s2_vld_r;
  logic [TW-1:0]      s2_t_r;
  logic               found_r;
  logic [CLASS_W-1:0] cls_r;

  sum_t               thr_r;
  logic [CLASS_W-1:0] extra_cls_r;

  sum_t               sum_mem [NUM_TEMPLATES];
  logic [NUM_TEMPLATES-1:0] sum_vld_r;
  sum_t               sum_rd_r;
  logic               sum_rd_vld_r;

  pixel_t             tmpl_rd;
  logic               accept;
  logic               in_range;
  logic               load_en;
  logic [TMPL_AW-1:0] load_addr;

  sum_t               sum_old;
  logic [PIX_W-1:0]   diff;
  logic [SUM_W:0]     sum_wide;
  sum_t               sum_nxt;
  logic               hit;
  logic [CLASS_W-1:0] t_cls;
  logic               found_nxt;
  logic [CLASS_W-1:0] cls_nxt;
  logic [CLASS_W-1:0] cls_tbl [NUM_TEMPLATES];

  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign in_range  = int'(in_pixel_index) < PIX;
  assign load_en   = accept && !in_req_type && in_range &&
                     (int'(in_template_index) < NUM_TEMPLATES);
  assign load_addr = TMPL_AW'(int'(in_template_index) * PIX + int'(in_pixel_index));

  // class of each regular template, fixed at elaboration
  for (genvar g = 0; g < NUM_TEMPLATES; g++) begin : g_cls
    assign cls_tbl[g] = CLASS_W'(g / TEMPLATES_PER_CLASS + 1);
  end

  sdm_tmpl_ram #(
    .DEPTH  (DEPTH),
    .ADDR_W (TMPL_AW)
  ) u_tmpl_ram (
    .clk     (clk),
    .wr_en   (load_en),
    .wr_addr (load_addr),
    .wr_data (in_pixel_value),
    .rd_addr (addr_r),
    .rd_data (tmpl_rd)
  );

  // Sequencer: issue one template per cycle, then drain the last write-back.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= (state_r == ST_SCAN);
      case (state_r)
        ST_IDLE: begin
          if (accept && in_req_type) begin
            state_r <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (step_r == LAST_T) begin
            state_r <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          state_r <= ST_IDLE;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_req_type) begin
      step_r     <= '0;
      // park the read address on entry 0 when the pixel is out of range
      addr_r     <= in_range ? TMPL_AW'(in_pixel_index) : '0;
      px_r       <= in_pixel_value;
      in_range_r <= in_range;
      last_r     <= in_last_pixel;
    end else if ((state_r == ST_SCAN) && (step_r != LAST_T)) begin
      step_r <= step_r + 1'b1;
      addr_r <= addr_r + TMPL_AW'(PIX);
    end
    s2_t_r <= step_r;
  end

  // Sum memory: read in the issue cycle, write back in the next cycle.
  always_ff @(posedge clk) begin
    sum_rd_r <= sum_mem[step_r];
    if (s2_vld_r) begin
      sum_mem[s2_t_r] <= last_r ? '0 : sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_vld_r    <= '0;
      sum_rd_vld_r <= 1'b0;
    end else begin
      sum_rd_vld_r <= sum_vld_r[step_r];
      if (s2_vld_r) begin
        sum_vld_r[s2_t_r] <= 1'b1;
      end
    end
  end

  // Accumulate with saturation and pick the first template below threshold.
  always_comb begin
    sum_old  = sum_rd_vld_r ? sum_rd_r : '0;
    diff     = (px_r > tmpl_rd) ? (px_r - tmpl_rd) : (tmpl_rd - px_r);
    sum_wide = {1'b0, sum_old} + {{(SUM_W + 1 - PIX_W){1'b0}}, diff};
    if (!in_range_r) begin
      sum_nxt = sum_old;
    end else if (sum_wide[SUM_W]) begin
      sum_nxt = '1;
    end else begin
      sum_nxt = sum_wide[SUM_W-1:0];
    end
    if (s2_t_r == LAST_T) begin
      t_cls = extra_cls_r;
    end else begin
      t_cls = cls_tbl[s2_t_r];
    end
    hit       = s2_vld_r && last_r && !found_r && (sum_nxt < thr_r);
    found_nxt = found_r || hit;
    cls_nxt   = hit ? t_cls : cls_r;
  end

  always_ff @(posedge clk) begin
    if (accept && in_req_type) begin
      found_r <= 1'b0;
      cls_r   <= '0;
    end else begin
      found_r <= found_nxt;
      cls_r   <= cls_nxt;
    end
  end

  // Result word: one-cycle strobe after the last write-back of a final pixel.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe <= 1'b0;
    end else begin
      out_strobe <= (state_r == ST_DRAIN) && last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_DRAIN) begin
      out_match_found <= found_nxt;
      out_digit_class <= cls_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r       <= THRESHOLD_RESET;
      extra_cls_r <= EXTRA_CLASS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SAD_THRESHOLD: thr_r       <= cfg_data;
        CFG_EXTRA_CLASS:   extra_cls_r <= cfg_data[CLASS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  `SDM_ASSERT(a_strobe_after_drain, !out_strobe || ($past(state_r) == ST_DRAIN), "strobe without drain")
  `SDM_ASSERT_NEXT(a_pixel_starts_scan, accept && in_req_type, state_r == ST_SCAN, "pixel word did not start a scan")
  `SDM_ASSERT(a_writeback_while_busy, !s2_vld_r || busy, "sum write-back while idle")
  `SDM_ASSERT(a_no_match_class_zero, !(out_strobe && !out_match_found) || (out_digit_class == '0), "class set without a match")

endmodule

`default_nettype wire

// ----- dv/sad_template_digit_matcher_unit_tb.sv -----
// Self-checking bench for sad_template_digit_matcher_unit: loads templates, streams candidate
// frames and compares every reported match with a SAD tracker kept alongside the block.
// Depends on sdm_pkg and the matcher RTL only.
`timescale 1ns / 1ps

module sad_template_digit_matcher_unit_tb
  import sdm_pkg::*;
();

  localparam int NUM_T      = NUM_TEMPLATES_DEF;
  localparam int PER_CLASS  = TEMPLATES_PER_CLASS_DEF;
  localparam int IMG_PIX    = IMAGE_SIDE_DEF * IMAGE_SIDE_DEF;
  localparam int SUM_SAT    = (1 << SUM_W) - 1;
  localparam int CLK_HALF   = 5;
  localparam int SETTLE_CYC = NUM_T + 8;
  localparam int DRAIN_MAX  = 400;
  localparam int MAX_POS    = 24;
  localparam int LONG_PIXELS = 40;
  localparam longint TIMEOUT_NS = 50_000_000;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_PIXEL = 1'b1;

  typedef struct packed {
    logic               found;
    logic [CLASS_W-1:0] cls;
  } match_word_t;

  // Tracks templates, running sums and registers; one expected word per last pixel.
  class sad_match_tracker;
    sum_t               threshold;
    logic [CLASS_W-1:0] extra_cls;
    pixel_t             tmpl_mem [int];
    sum_t               diff_sum [NUM_T];
    match_word_t        expected_matches [$];
    int                 errors;

    function new();
      threshold = THRESHOLD_RESET;
      extra_cls = EXTRA_CLASS_RESET;
      errors    = 0;
      foreach (diff_sum[t]) diff_sum[t] = '0;
    endfunction

    function pixel_t pixel_at(int t, int p);
      return tmpl_mem.exists(t * IMG_PIX + p) ? tmpl_mem[t * IMG_PIX + p] : '0;
    endfunction

    function void write_reg(logic idx, logic [SUM_W-1:0] data);
      if (idx == CFG_SAD_THRESHOLD) threshold = data;
      else extra_cls = data[CLASS_W-1:0];
    endfunction

    function void note_word(logic req, logic [5:0] tidx, logic [13:0] pidx, pixel_t val,
                            logic last);
      int d;
      int s;
      match_word_t w;
      if (req == REQ_LOAD) begin
        if (tidx < NUM_T && pidx < IMG_PIX) tmpl_mem[int'(tidx) * IMG_PIX + int'(pidx)] = val;
        return;
      end
      if (pidx < IMG_PIX) begin
        for (int t = 0; t < NUM_T; t++) begin
          d = int'(val) - int'(pixel_at(t, int'(pidx)));
          if (d < 0) d = -d;
          s = int'(diff_sum[t]) + d;
          diff_sum[t] = SUM_W'((s > SUM_SAT) ? SUM_SAT : s);
        end
      end
      if (!last) return;
      w = '0;
      for (int t = 0; t < NUM_T; t++) begin
        if (diff_sum[t] < threshold) begin
          w.found = 1'b1;
          w.cls   = (t == NUM_T - 1) ? extra_cls : CLASS_W'(t / PER_CLASS + 1);
          break;
        end
      end
      expected_matches = {expected_matches, w};
      foreach (diff_sum[t]) diff_sum[t] = '0;
    endfunction

    function void check_result(logic found, logic [CLASS_W-1:0] cls);
      match_word_t w;
      if (expected_matches.size() == 0) begin
        $error("unexpected result word: match_found=%0d digit_class=%0d", found, cls);
        errors++;
        return;
      end
      w = expected_matches.pop_front();
      if (found !== w.found) begin
        $error("match_found: expected %0d, actual %0d", w.found, found);
        errors++;
      end
      if (cls !== w.cls) begin
        $error("digit_class: expected %0d, actual %0d", w.cls, cls);
        errors++;
      end
    endfunction

    function int pending();
      return expected_matches.size();
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic               in_req_type = 1'b0;
  logic [5:0]         in_template_index = '0;
  logic [13:0]        in_pixel_index = '0;
  logic [7:0]         in_pixel_value = '0;
  logic               in_last_pixel = 1'b0;
  logic               out_strobe;
  logic               out_match_found;
  logic [CLASS_W-1:0] out_digit_class;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic               cfg_index = 1'b0;
  logic [SUM_W-1:0]   cfg_data = '0;

  sad_match_tracker tracker = new();
  int  ready_pos [$];
  bit  is_ready [int];
  bit  idle_on = 1'b1;
  int  words_counted = 0;

  sad_template_digit_matcher_unit uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_req_type       (in_req_type),
    .in_template_index (in_template_index),
    .in_pixel_index    (in_pixel_index),
    .in_pixel_value    (in_pixel_value),
    .in_last_pixel     (in_last_pixel),
    .out_strobe        (out_strobe),
    .out_match_found   (out_match_found),
    .out_digit_class   (out_digit_class),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always #CLK_HALF clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_strobe) tracker.check_result(out_match_found, out_digit_class);
  end

  initial begin
    #TIMEOUT_NS;
    $display("sad_template_digit_matcher_unit_tb: done, errors");
    $finish;
  end

  // Present one word and hold it until the block takes it.
  task automatic send_word(logic req, logic [5:0] tidx, logic [13:0] pidx, pixel_t val,
                           logic last, bit counted);
    int gap;
    gap = 0;
    if (idle_on) begin
      if ($urandom_range(99) < 4) gap = $urandom_range(1, NUM_T + 12);
      else while ($urandom_range(99) < 21) gap++;
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start             <= 1'b1;
    in_req_type       <= req;
    in_template_index <= tidx;
    in_pixel_index    <= pidx;
    in_pixel_value    <= val;
    in_last_pixel     <= last;
    do @(posedge clk); while (busy);
    tracker.note_word(req, tidx, pidx, val, last);
    if (counted) words_counted++;
  endtask

  // Wait for every expected word, then let a non-last pixel finish its pass.
  task automatic drain_results();
    int n;
    start <= 1'b0;
    for (n = 0; n < DRAIN_MAX && tracker.pending() != 0; n++) @(posedge clk);
    if (tracker.pending() != 0) begin
      $error("%0d expected result words never arrived", tracker.pending());
      tracker.errors++;
    end
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_cfg(logic idx, int unsigned data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= SUM_W'(data);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    tracker.write_reg(idx, SUM_W'(data));
    @(posedge clk);
  endtask

  // Candidate frame that mostly follows one template, with some stray pixels.
  task automatic send_frame(int len, int tgt, int noise);
    logic [13:0] pidx;
    int v;
    for (int k = 0; k < len; k++) begin
      if ($urandom_range(99) < 8) pidx = 14'($urandom_range(IMG_PIX, 16383));
      else pidx = 14'(ready_pos[$urandom_range(ready_pos.size() - 1)]);
      if ($urandom_range(99) < 25 || pidx >= IMG_PIX) begin
        v = $urandom_range(255);
      end else begin
        v = int'(tracker.pixel_at(tgt, int'(pidx))) + $urandom_range(2 * noise) - noise;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
      end
      send_word(REQ_PIXEL, 6'($urandom_range(63)), pidx, 8'(v), k == len - 1, 1'b1);
    end
  endtask

  task automatic load_template_pixels();
    int p;
    if (ready_pos.size() < MAX_POS && $urandom_range(99) < 15) begin
      // fill a new position in every template before any frame may read it
      p = $urandom_range(IMG_PIX - 1);
      for (int t = 0; t < NUM_T; t++)
        send_word(REQ_LOAD, 6'(t), 14'(p), 8'($urandom_range(255)), 1'($urandom_range(1)),
                  1'b1);
      if (!is_ready.exists(p)) begin
        is_ready[p] = 1'b1;
        ready_pos = {ready_pos, p};
      end
    end else begin
      p = ready_pos[$urandom_range(ready_pos.size() - 1)];
      repeat ($urandom_range(1, 6))
        send_word(REQ_LOAD, 6'($urandom_range(NUM_T - 1)), 14'(p), 8'($urandom_range(255)),
                  1'($urandom_range(1)), 1'b1);
    end
  endtask

  // Loads the block must drop: template or pixel index out of range.
  task automatic send_ignored_load();
    if ($urandom_range(1))
      send_word(REQ_LOAD, 6'($urandom_range(NUM_T, 63)), 14'($urandom_range(16383)),
                8'($urandom_range(255)), 1'($urandom_range(1)), 1'b0);
    else
      send_word(REQ_LOAD, 6'($urandom_range(NUM_T - 1)), 14'($urandom_range(IMG_PIX, 16383)),
                8'($urandom_range(255)), 1'($urandom_range(1)), 1'b0);
  endtask

  initial begin
    int probe_t [8] = '{0, 7, 8, 15, 16, 24, 31, 32};
    int init_pos [8];
    int goal;
    int sel;
    int thr;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // position 0 gets a distinct value per template, 9999 is all zero
    init_pos = '{0, 9999, 99, 9900, 5050, 8192, 1234, $urandom_range(IMG_PIX - 1)};
    foreach (init_pos[i]) begin
      for (int t = 0; t < NUM_T; t++) begin
        if (i == 0) sel = 7 * t;
        else if (i == 1) sel = 0;
        else sel = $urandom_range(255);
        send_word(REQ_LOAD, 6'(t), 14'(init_pos[i]), 8'(sel), 1'b0, 1'b1);
      end
      if (!is_ready.exists(init_pos[i])) begin
        is_ready[init_pos[i]] = 1'b1;
        ready_pos = {ready_pos, init_pos[i]};
      end
    end

    // dropped loads, a load with the last mark, and frames with out-of-range pixels
    send_word(REQ_LOAD, 6'd63, 14'd0, 8'hFF, 1'b1, 1'b0);
    send_word(REQ_LOAD, 6'd5, 14'h3FFF, 8'hAA, 1'b0, 1'b0);
    send_word(REQ_LOAD, 6'd0, 14'd99, 8'h55, 1'b1, 1'b1);
    send_word(REQ_PIXEL, 6'd0, 14'h3FFF, 8'hFF, 1'b1, 1'b1);
    send_word(REQ_PIXEL, 6'd63, 14'd0, 8'h00, 1'b0, 1'b1);
    send_word(REQ_PIXEL, 6'd0, 14'd9999, 8'hFF, 1'b1, 1'b1);

    // one-pixel frames that hit exactly one template, one per class boundary
    drain_results();
    write_cfg(CFG_SAD_THRESHOLD, 1);
    foreach (probe_t[i]) send_word(REQ_PIXEL, 6'd0, 14'd0, 8'(7 * probe_t[i]), 1'b1, 1'b1);
    drain_results();
    write_cfg(CFG_EXTRA_CLASS, 22'h3FFFF8);
    send_word(REQ_PIXEL, 6'd0, 14'd0, 8'(7 * (NUM_T - 1)), 1'b1, 1'b1);
    drain_results();
    write_cfg(CFG_EXTRA_CLASS, 0);
    send_word(REQ_PIXEL, 6'd0, 14'd0, 8'(7 * (NUM_T - 1)), 1'b1, 1'b1);
    drain_results();
    write_cfg(CFG_EXTRA_CLASS, 15);
    send_word(REQ_PIXEL, 6'd0, 14'd0, 8'(7 * (NUM_T - 1)), 1'b1, 1'b1);
    drain_results();
    write_cfg(CFG_SAD_THRESHOLD, 0);
    send_word(REQ_PIXEL, 6'd0, 14'd0, 8'd0, 1'b1, 1'b1);
    drain_results();
    write_cfg(CFG_SAD_THRESHOLD, 2550001);
    send_word(REQ_PIXEL, 6'd0, 14'd0, 8'hFF, 1'b0, 1'b1);
    send_word(REQ_PIXEL, 6'd0, 14'd9999, 8'hFF, 1'b1, 1'b1);

    // long frame on the all-zero position with the threshold at its top value
    drain_results();
    write_cfg(CFG_SAD_THRESHOLD, SUM_SAT);
    for (int k = 0; k < LONG_PIXELS; k++)
      send_word(REQ_PIXEL, 6'd0, 14'd9999, 8'hFF, k == LONG_PIXELS - 1, 1'b1);

    for (int ph = 0; ph < 6; ph++) begin
      drain_results();
      case ($urandom_range(4))
        0: thr = 0;
        1: thr = 2550001;
        2: thr = $urandom_range(2000);
        3: thr = $urandom_range(2550001);
        default: thr = $urandom_range(400);
      endcase
      write_cfg(CFG_SAD_THRESHOLD, thr);
      write_cfg(CFG_EXTRA_CLASS, $urandom_range(15));
      idle_on = (ph != 2);
      goal = words_counted + 250;
      while (words_counted < goal) begin
        sel = $urandom_range(99);
        if (sel < 60) send_frame($urandom_range(1, 12), $urandom_range(NUM_T - 1),
                                 $urandom_range(3));
        else if (sel < 85) load_template_pixels();
        else send_ignored_load();
      end
    end

    drain_results();
    if (tracker.errors == 0) begin
      $display("sad_template_digit_matcher_unit_tb: done, clean");
    end else begin
      $display("sad_template_digit_matcher_unit_tb: done, errors");
    end
    $finish;
  end

endmodule
